@@ rtl/hashed_slot_depth_replace_macros.svh @@
// Assertion macros for the hashed slot table.
// Included by the top level; no other dependencies.
`ifndef HASHED_SLOT_DEPTH_REPLACE_MACROS_SVH
`define HASHED_SLOT_DEPTH_REPLACE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define HSDR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define HSDR_ASSERT_IMPLY(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Check that a trigger implies a condition in the following cycle.
`define HSDR_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

@@ rtl/hsdr_pkg.sv @@
// Shared types, constants and codes of the hashed slot table.
// No dependencies; the files that use this package refer to it by scoped names.
package hsdr_pkg;

   localparam int SLOTS_DEFAULT = 15;

   localparam int KEY_W      = 64;
   localparam int FACE_W     = 8;
   localparam int DEPTH_W    = 8;
   localparam int COUNT_W    = 32;
   localparam int SLOT_OUT_W = 4;
   localparam int OUTCOME_W  = 2;
   localparam int OCC_OUT_W  = 4;
   localparam int ENTRY_W    = KEY_W + FACE_W + DEPTH_W;

   localparam logic [63:0] GOLDEN = 64'h9E37_79B1_85EB_CA87;
   localparam logic [63:0] MIX_A  = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_B  = 64'h94D0_49BB_1331_11EB;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_INIT   = 1'b1;

   localparam logic [OUTCOME_W-1:0] OUT_FILLED    = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_REPLACED  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_EQUAL     = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_SHALLOWER = 2'd3;

   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  key;
      logic [FACE_W-1:0] face;
   } hash_cmd_type;

endpackage

@@ rtl/hsdr_if.sv @@
// Request and response channel interfaces of the hashed slot table.
// Depends on hsdr_pkg for field widths.
interface hsdr_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [hsdr_pkg::KEY_W-1:0]   key_core;
   logic [hsdr_pkg::FACE_W-1:0]  face_code;
   logic [hsdr_pkg::DEPTH_W-1:0] entry_depth;

   modport source (output valid, opcode, key_core, face_code, entry_depth, input ready);
   modport sink (input valid, opcode, key_core, face_code, entry_depth, output ready);
endinterface

interface hsdr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            accepted;
   logic [hsdr_pkg::SLOT_OUT_W-1:0] slot_index;
   logic [hsdr_pkg::OUTCOME_W-1:0]  outcome;
   logic [hsdr_pkg::OCC_OUT_W-1:0]  occupied_count;
   logic [hsdr_pkg::COUNT_W-1:0]    write_count;
   logic [hsdr_pkg::COUNT_W-1:0]    evicted_count;
   logic [hsdr_pkg::COUNT_W-1:0]    kept_count;
   logic [hsdr_pkg::COUNT_W-1:0]    rejected_count;

   modport source (output valid, accepted, slot_index, outcome, occupied_count, write_count,
                   evicted_count, kept_count, rejected_count, input ready);
   modport sink (input valid, accepted, slot_index, outcome, occupied_count, write_count,
                 evicted_count, kept_count, rejected_count, output ready);
endinterface

@@ rtl/hsdr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hsdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/hsdr_hash.sv @@
// Iterative key/face hash and slot reduction: one shared 32x32 multiplier,
// then a byte-serial remainder by the slot count. Depends on hsdr_pkg.
module hsdr_hash #(
   parameter int SLOTS = hsdr_pkg::SLOTS_DEFAULT,
   localparam int IW = $clog2(SLOTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hsdr_pkg::hash_cmd_type cmd,
   output logic                   done,
   output logic [IW-1:0]          slot
);

   localparam int VW = IW + 8;

   localparam logic [1:0] H_IDLE = 2'd0;
   localparam logic [1:0] H_MUL  = 2'd1;
   localparam logic [1:0] H_MOD  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [63:0]   x_ff, x_in;
   logic [63:0]   acc_ff, acc_in;
   logic [1:0]    step_ff, step_in;
   logic          second_ff, second_in;
   logic [2:0]    byte_ff, byte_in;
   logic [IW-1:0] rem_ff, rem_in;
   logic          done_ff, done_in;

   logic [63:0] gold_prod;
   logic [63:0] seed;
   logic [63:0] mul_b;
   logic [31:0] mul_a;
   logic [31:0] mul_bsel;
   logic [63:0] prod;
   logic [31:0] hi_sum;
   logic [63:0] full;
   logic [VW-1:0] part;

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      second_in = second_ff;
      byte_in   = byte_ff;
      rem_in    = rem_ff;
      done_in   = 1'b0;

      // Pre-mix: fold the face in by the golden constant, then xor-shift.
      gold_prod = cmd.face * hsdr_pkg::GOLDEN;
      seed      = cmd.key ^ gold_prod;

      // Low 64 bits of x * constant: lo*lo, then the two cross terms.
      mul_b    = second_ff ? hsdr_pkg::MIX_B : hsdr_pkg::MIX_A;
      mul_a    = (step_ff == 2'd2) ? x_ff[63:32] : x_ff[31:0];
      mul_bsel = (step_ff == 2'd1) ? mul_b[63:32] : mul_b[31:0];
      prod     = {32'd0, mul_a} * {32'd0, mul_bsel};
      hi_sum   = acc_ff[63:32] + prod[31:0];
      full     = {hi_sum, acc_ff[31:0]};

      // Remainder step: bring in one byte, restoring-subtract eight times.
      part = {rem_ff, x_ff[63:56]};
      for (int k = 7; k >= 0; k--) begin
         if (part >= (VW'(SLOTS) << k)) begin
            part = part - (VW'(SLOTS) << k);
         end
      end

      unique case (state_ff)
         H_IDLE: begin
            if (cmd.start) begin
               x_in      = seed ^ (seed >> 30);
               step_in   = 2'd0;
               second_in = 1'b0;
               state_in  = H_MUL;
            end
         end
         H_MUL: begin
            unique case (step_ff)
               2'd0: begin
                  acc_in  = prod;
                  step_in = 2'd1;
               end
               2'd1: begin
                  acc_in  = full;
                  step_in = 2'd2;
               end
               2'd2: begin
                  step_in = 2'd0;
                  if (!second_ff) begin
                     x_in      = full ^ (full >> 27);
                     second_in = 1'b1;
                  end else begin
                     x_in     = full ^ (full >> 31);
                     byte_in  = 3'd0;
                     rem_in   = '0;
                     state_in = H_MOD;
                  end
               end
               default: step_in = 2'd0;
            endcase
         end
         H_MOD: begin
            rem_in  = part[IW-1:0];
            x_in    = x_ff << 8;
            byte_in = byte_ff + 3'd1;
            if (byte_ff == 3'd7) begin
               done_in  = 1'b1;
               state_in = H_IDLE;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= H_IDLE;
         step_ff   <= 2'd0;
         second_ff <= 1'b0;
         byte_ff   <= 3'd0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         second_ff <= second_in;
         byte_ff   <= byte_in;
         done_ff   <= done_in;
      end
      x_ff   <= x_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign slot = rem_ff;

endmodule

@@ rtl/hashed_slot_depth_replace.sv @@
// Top level of the hashed slot table: request/response handshake, slot store,
// valid bits and counters. Depends on hsdr_pkg, hsdr_if, hsdr_ram, hsdr_hash.
//
// A direct-mapped table of SLOTS entries (2 to 256). An insert request hashes
// its key and face code (golden-constant pre-mix, then a 64-bit xor-shift /
// multiply mixer), takes the hash modulo SLOTS as the slot, and writes the
// entry if the slot is empty or holds a greater depth; an equal depth counts
// as kept, a smaller held depth as rejected. An init request clears every
// slot and the write count, then seeds slot 0 with the key at depth 0. Reset
// leaves the table empty and all counters at zero; no clearing pass is needed,
// since one valid flip-flop per slot marks occupancy. One request is in work
// at a time. An insert runs from acceptance to the next acceptance through
// the shared 32x32 multiplier (three partial products per mixer multiply;
// the golden pre-mix rides on the request bus in the accept cycle), 8 byte
// steps of the remainder, the capture of the slot, one slot memory read, the
// decide and write-back, and the idle state that takes the next request. An
// init goes from idle straight to the decide and write-back. The response
// register frees the request side: a response waiting to be taken does not
// block acceptance, only the commit of the next one. The counters wrap at 32
// bits; slot_index and occupied_count carry their low 4 bits.
`include "hashed_slot_depth_replace_macros.svh"

module hashed_slot_depth_replace #(
   parameter int SLOTS = hsdr_pkg::SLOTS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   hsdr_req_if.sink   req_chan,
   hsdr_rsp_if.source rsp_chan
);

   localparam int IW = $clog2(SLOTS);
   localparam int OW = $clog2(SLOTS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_HASH   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0] state_ff, state_in;

   // Held request fields.
   logic                         op_ff;
   logic [hsdr_pkg::KEY_W-1:0]   key_ff;
   logic [hsdr_pkg::FACE_W-1:0]  face_ff;
   logic [hsdr_pkg::DEPTH_W-1:0] depth_ff;
   logic [IW-1:0]                idx_ff, idx_in;

   // Table occupancy and statistics.
   logic [SLOTS-1:0]             valid_ff, valid_in;
   logic [OW-1:0]                occ_ff, occ_in;
   logic [hsdr_pkg::COUNT_W-1:0] ins_ff, ins_in;
   logic [hsdr_pkg::COUNT_W-1:0] evict_ff, evict_in;
   logic [hsdr_pkg::COUNT_W-1:0] keep_ff, keep_in;
   logic [hsdr_pkg::COUNT_W-1:0] reject_ff, reject_in;

   // Response register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_acc_ff;
   logic [hsdr_pkg::OUTCOME_W-1:0]   rsp_outcome_ff;
   logic [hsdr_pkg::SLOT_OUT_W-1:0]  rsp_slot_ff;

   logic                   req_accept;
   logic                   slot_free;
   logic                   commit;
   logic                   held_valid;
   logic [hsdr_pkg::DEPTH_W-1:0] held_depth;
   logic                   do_write;
   logic [hsdr_pkg::OUTCOME_W-1:0] outcome;

   logic [hsdr_pkg::ENTRY_W-1:0] rd_entry;
   logic [hsdr_pkg::ENTRY_W-1:0] wr_entry;

   hsdr_pkg::hash_cmd_type hash_cmd;
   logic                   hash_done;
   logic [IW-1:0]          hash_slot;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Start the hash straight from the request bus; init skips it.
   assign hash_cmd.start = req_accept && (req_chan.opcode == hsdr_pkg::OP_INSERT);
   assign hash_cmd.key   = req_chan.key_core;
   assign hash_cmd.face  = req_chan.face_code;

   hsdr_hash #(.SLOTS(SLOTS)) u_hash (
      .clock (clock),
      .reset (reset),
      .cmd   (hash_cmd),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   // Slot store: {key, face, depth}. The read address is held in idx_ff, so
   // read data stays put while a commit waits for the response register.
   hsdr_ram #(.WIDTH(hsdr_pkg::ENTRY_W), .DEPTH(SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (rd_entry)
   );

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign commit    = (state_ff == ST_DECIDE) && slot_free;

   assign held_valid = valid_ff[idx_ff];
   assign held_depth = rd_entry[hsdr_pkg::DEPTH_W-1:0];

   // Classify the request against the held entry.
   always_comb begin
      priority if (op_ff == hsdr_pkg::OP_INIT) begin
         outcome = hsdr_pkg::OUT_FILLED;
      end else if (!held_valid) begin
         outcome = hsdr_pkg::OUT_FILLED;
      end else if (held_depth > depth_ff) begin
         outcome = hsdr_pkg::OUT_REPLACED;
      end else if (held_depth == depth_ff) begin
         outcome = hsdr_pkg::OUT_EQUAL;
      end else begin
         outcome = hsdr_pkg::OUT_SHALLOWER;
      end
   end

   assign do_write = commit && ((outcome == hsdr_pkg::OUT_FILLED) ||
                                (outcome == hsdr_pkg::OUT_REPLACED));

   // Init seeds slot 0 with face 0 and depth 0.
   assign wr_entry = (op_ff == hsdr_pkg::OP_INIT) ?
                     {key_ff, {hsdr_pkg::FACE_W{1'b0}}, {hsdr_pkg::DEPTH_W{1'b0}}} :
                     {key_ff, face_ff, depth_ff};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      ins_in       = ins_ff;
      evict_in     = evict_ff;
      keep_in      = keep_ff;
      reject_in    = reject_ff;
      rsp_valid_in = rsp_valid_ff;

      // Drop the response once taken; a commit below reloads it.
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.opcode == hsdr_pkg::OP_INIT) begin
                  idx_in   = '0;
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               idx_in   = hash_slot;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == hsdr_pkg::OP_INIT) begin
                  valid_in = SLOTS'(1);
                  occ_in   = OW'(1);
                  ins_in   = '0;
               end else begin
                  unique case (outcome)
                     hsdr_pkg::OUT_FILLED: begin
                        valid_in = valid_ff | (SLOTS'(1) << idx_ff);
                        occ_in   = occ_ff + OW'(1);
                        ins_in   = ins_ff + 32'd1;
                     end
                     hsdr_pkg::OUT_REPLACED: begin
                        evict_in = evict_ff + 32'd1;
                        ins_in   = ins_ff + 32'd1;
                     end
                     hsdr_pkg::OUT_EQUAL: keep_in = keep_ff + 32'd1;
                     hsdr_pkg::OUT_SHALLOWER: reject_in = reject_ff + 32'd1;
                     default: state_in = ST_IDLE;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         occ_ff       <= '0;
         ins_ff       <= '0;
         evict_ff     <= '0;
         keep_ff      <= '0;
         reject_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         ins_ff       <= ins_in;
         evict_ff     <= evict_in;
         keep_ff      <= keep_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
      end

      // Hold the request fields for the whole operation.
      if (req_accept) begin
         op_ff    <= req_chan.opcode;
         key_ff   <= req_chan.key_core;
         face_ff  <= req_chan.face_code;
         depth_ff <= req_chan.entry_depth;
      end
      idx_ff <= idx_in;

      if (commit) begin
         rsp_acc_ff     <= (outcome == hsdr_pkg::OUT_FILLED) ||
                           (outcome == hsdr_pkg::OUT_REPLACED);
         rsp_outcome_ff <= outcome;
         rsp_slot_ff    <= hsdr_pkg::SLOT_OUT_W'(idx_ff);
      end
   end

   // Counters change only at a commit, which also reloads the response, so
   // the response reads them directly.
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.accepted       = rsp_acc_ff;
   assign rsp_chan.slot_index     = rsp_slot_ff;
   assign rsp_chan.outcome        = rsp_outcome_ff;
   assign rsp_chan.occupied_count = hsdr_pkg::OCC_OUT_W'(occ_ff);
   assign rsp_chan.write_count    = ins_ff;
   assign rsp_chan.evicted_count  = evict_ff;
   assign rsp_chan.kept_count     = keep_ff;
   assign rsp_chan.rejected_count = reject_ff;

   // Occupancy count tracks the valid bits.
   `HSDR_ASSERT_ALWAYS(a_occ_matches_valid, clock, reset, occ_ff == OW'($countones(valid_ff)), "occupancy count disagrees with valid bits")
   // A finished hash is only seen while waiting for it.
   `HSDR_ASSERT_IMPLY(a_hash_done_waited, clock, reset, hash_done, state_ff == ST_HASH, "hash finished outside its wait state")
   // The remainder unit never yields a slot past the table.
   `HSDR_ASSERT_IMPLY(a_hash_slot_range, clock, reset, hash_done, 32'(hash_slot) < 32'(SLOTS), "hash slot out of range")
   // Init leaves only slot 0 occupied.
   `HSDR_ASSERT_NEXT(a_init_seeds_zero, clock, reset, commit && (op_ff == hsdr_pkg::OP_INIT), valid_ff == SLOTS'(1), "init did not seed slot 0 alone")

endmodule
